// File: design/dcf_pkg.sv
// ----------------------------------------------------------------------------
// dcf_pkg
// Shared types and codes for the dominant color fade pixel block.
// ----------------------------------------------------------------------------
package dcf_pkg;

	// Signed 7-bit fader value, as held in the registers and positions
	typedef logic signed [6:0] fade_t;

	// Item kinds carried on cmd
	typedef enum logic {
		CMD_FRAME = 1'b0,
		CMD_PIXEL = 1'b1
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_ENABLED        = 3'd0,
		CFG_FADE_LOW       = 3'd1,
		CFG_FADE_MID       = 3'd2,
		CFG_FADE_HIGH      = 3'd3,
		CFG_BEAT_MODE      = 3'd4,
		CFG_BEAT_FADE_LOW  = 3'd5,
		CFG_BEAT_FADE_MID  = 3'd6,
		CFG_BEAT_FADE_HIGH = 3'd7
	} cfg_idx_t;

	// Beat mode codes; bit one alone selects random draws
	localparam logic [1:0] BEAT_NONE = 2'd0;
	localparam logic [1:0] BEAT_LOAD = 2'd1;
	localparam int unsigned BEAT_RAND_BIT = 1;

	localparam int unsigned CFG_DATA_W = 7;

	// Draw offsets
	localparam fade_t DRAW_BIAS   = 7'sd6;
	localparam fade_t DRAW_B_BIAS = 7'sd32;
	localparam fade_t DRAW_B_NEAR = 7'sd16;
	localparam fade_t DRAW_B_FAR  = 7'sd32;

	// Register file contents
	typedef struct packed {
		logic       enabled;
		fade_t      fade_low;
		fade_t      fade_mid;
		fade_t      fade_high;
		logic [1:0] beat_mode;
		fade_t      beat_fade_low;
		fade_t      beat_fade_mid;
		fade_t      beat_fade_high;
	} cfg_t;

	// Frame-start request handed to the fader unit
	typedef struct packed {
		logic       upd;
		logic       beat;
		logic       skip;
		logic [4:0] draw_a;
		logic [5:0] draw_b;
		logic [4:0] draw_c;
	} frame_req_t;

	// Fader state seen by the pixel path
	typedef struct packed {
		logic            active;
		fade_t [2:0]     pos;
	} fader_state_t;

endpackage

// File: design/dcf_fader.sv
// ----------------------------------------------------------------------------
// dcf_fader
// Fader positions and frame-active flag, updated once per frame-start request.
// ----------------------------------------------------------------------------
module dcf_fader (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dcf_pkg::cfg_t        cfg,
	input  dcf_pkg::frame_req_t  req,
	output dcf_pkg::fader_state_t state
);
	import dcf_pkg::*;

	fade_t [2:0] pos_q;
	logic        active_q;
	fade_t [2:0] pos_d;
	logic        active_d;
	fade_t       rnd_b;
	fade_t       vb;

	function automatic fade_t step_toward(input fade_t p, input fade_t t);
		if (p < t) begin
			return p + 7'sd1;
		end else if (p > t) begin
			return p - 7'sd1;
		end
		return p;
	endfunction

	// Fold draw_b into a value far from zero
	always_comb begin
		vb = $signed({1'b0, req.draw_b}) - DRAW_B_BIAS;
		if (vb < 0 && vb > -DRAW_B_NEAR) begin
			rnd_b = -DRAW_B_FAR;
		end else if (vb >= 0 && vb < DRAW_B_NEAR) begin
			rnd_b = DRAW_B_FAR;
		end else begin
			rnd_b = vb;
		end
	end

	// Pick the next positions; in the step branch the mid and high targets stay crossed
	always_comb begin
		active_d = active_q;
		pos_d    = pos_q;
		if (req.upd) begin
			active_d = cfg.enabled && !req.skip;
			if (active_d) begin
				priority if (cfg.beat_mode == BEAT_NONE) begin
					pos_d[0] = cfg.fade_low;
					pos_d[1] = cfg.fade_mid;
					pos_d[2] = cfg.fade_high;
				end else if (req.beat && cfg.beat_mode[BEAT_RAND_BIT]) begin
					pos_d[0] = $signed({2'b00, req.draw_a}) - DRAW_BIAS;
					pos_d[1] = rnd_b;
					pos_d[2] = $signed({2'b00, req.draw_c}) - DRAW_BIAS;
				end else if (req.beat) begin
					pos_d[0] = cfg.beat_fade_low;
					pos_d[1] = cfg.beat_fade_mid;
					pos_d[2] = cfg.beat_fade_high;
				end else begin
					pos_d[0] = step_toward(pos_q[0], cfg.fade_low);
					pos_d[1] = step_toward(pos_q[1], cfg.fade_high);
					pos_d[2] = step_toward(pos_q[2], cfg.fade_mid);
				end
			end
		end
	end

	// Hold state between frame starts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pos_q    <= '0;
		end else begin
			active_q <= active_d;
			pos_q    <= pos_d;
		end
	end

	assign state.active = active_q;
	assign state.pos    = pos_q;

	// Positions only move on a frame-start request
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!req.upd |=> $stable(pos_q) && $stable(active_q))
		else $error("fader state changed without a frame start");

	// An inactive frame leaves the positions alone
	a_skip_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req.upd && (!cfg.enabled || req.skip) |=> !active_q && $stable(pos_q))
		else $error("skipped frame changed fader positions");

	// Steps move the low position by at most one unit
	a_step_small: assert property (@(posedge clk) disable iff (!arst_n)
		req.upd && cfg.beat_mode != BEAT_NONE && !req.beat && cfg.enabled && !req.skip
		|=> (pos_q[0] - $past(pos_q[0]) <= 7'sd1) && ($past(pos_q[0]) - pos_q[0] <= 7'sd1))
		else $error("fader step larger than one unit");

endmodule

// File: design/dcf_pixel.sv
// ----------------------------------------------------------------------------
// dcf_pixel
// Dominant-channel classification and clamped fade of one pixel.
// ----------------------------------------------------------------------------
module dcf_pixel (
	input  logic                  enabled,
	input  dcf_pkg::fader_state_t state,
	input  logic [31:0]           pixel_in,
	output logic [31:0]           pixel_out
);
	import dcf_pkg::*;

	logic [7:0]        lo, mi, hi;
	logic signed [9:0] d1, d2;
	fade_t             o0, o1, o2;

	function automatic logic [7:0] add_clamp(input logic [7:0] b, input fade_t o);
		logic signed [9:0] s;
		s = $signed({2'b00, b}) + 10'(o);
		if (s < 0) begin
			return 8'd0;
		end else if (s[8]) begin
			return 8'hFF;
		end
		return s[7:0];
	endfunction

	assign lo = pixel_in[7:0];
	assign mi = pixel_in[15:8];
	assign hi = pixel_in[23:16];
	assign d1 = $signed({2'b00, mi}) - $signed({2'b00, hi});
	assign d2 = $signed({2'b00, hi}) - $signed({2'b00, lo});

	// Choose offsets by dominant channel; mid against low decides d1 versus -d2
	always_comb begin
		priority if (d1 > 0 && mi > lo) begin
			o0 = state.pos[2]; o1 = state.pos[1]; o2 = state.pos[0];
		end else if (d2 < 0 && mi < lo) begin
			o0 = state.pos[1]; o1 = state.pos[0]; o2 = state.pos[2];
		end else if (d1 < 0 && d2 > 0) begin
			o0 = state.pos[0]; o1 = state.pos[2]; o2 = state.pos[1];
		end else begin
			o0 = state.pos[2]; o1 = state.pos[2]; o2 = state.pos[2];
		end
	end

	// Pass the pixel through outside an active, enabled frame
	always_comb begin
		if (!state.active || !enabled) begin
			pixel_out = pixel_in;
		end else begin
			pixel_out = {pixel_in[31:24], add_clamp(hi, o2), add_clamp(mi, o1),
				add_clamp(lo, o0)};
		end
	end

endmodule

// File: design/dominant_color_fade_pixel.sv
// ----------------------------------------------------------------------------
// dominant_color_fade_pixel
// Per-frame fader update and per-pixel dominant color fade.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries two request kinds chosen
//   by cmd: a frame start (beat, skip_frame, draw_a/b/c) that updates three
//   fader positions, and a pixel that is faded with them. Each pixel request
//   yields one request on the output channel (out_valid / out_stall); a
//   frame start yields none.
//   A pixel passes the input register, then the result register, on its
//   way to the output. Throughput is one request per cycle while the
//   output does not stall; the fader update of a frame start is seen by
//   the very next pixel. When the receiver stalls, the result register
//   holds; one more pixel waits in the input register, after which
//   in_stall rises. Frame starts never wait on the output.
//   The configuration port (cfg_we, cfg_index, cfg_data) writes one register
//   per cycle and should be used only while no request is in flight.
//   Reset loads the register defaults, clears the faders and marks no frame
//   active, so pixels pass unchanged until the first frame start.
// ----------------------------------------------------------------------------
module dominant_color_fade_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [31:0] pixel_in,
	input  logic        beat,
	input  logic        skip_frame,
	input  logic [4:0]  draw_a,
	input  logic [5:0]  draw_b,
	input  logic [4:0]  draw_c,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] pixel_out,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [dcf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dcf_pkg::*;

	cfg_t         cfg_q;
	logic         valid_s1;
	cmd_t         cmd_s1;
	logic [31:0]  pixel_s1;
	logic         beat_s1, skip_s1;
	logic [4:0]   draw_a_s1, draw_c_s1;
	logic [5:0]   draw_b_s1;
	logic         valid_s2;
	logic [31:0]  pixel_s2;
	logic         adv_out;
	logic         take_s1;
	frame_req_t   freq;
	fader_state_t fstate;
	logic [31:0]  faded;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled        <= 1'b1;
			cfg_q.fade_low       <= 7'sd8;
			cfg_q.fade_mid       <= -7'sd8;
			cfg_q.fade_high      <= -7'sd8;
			cfg_q.beat_mode      <= BEAT_NONE;
			cfg_q.beat_fade_low  <= 7'sd8;
			cfg_q.beat_fade_mid  <= -7'sd8;
			cfg_q.beat_fade_high <= -7'sd8;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ENABLED:        cfg_q.enabled        <= cfg_data[0];
				CFG_FADE_LOW:       cfg_q.fade_low       <= cfg_data;
				CFG_FADE_MID:       cfg_q.fade_mid       <= cfg_data;
				CFG_FADE_HIGH:      cfg_q.fade_high      <= cfg_data;
				CFG_BEAT_MODE:      cfg_q.beat_mode      <= cfg_data[1:0];
				CFG_BEAT_FADE_LOW:  cfg_q.beat_fade_low  <= cfg_data;
				CFG_BEAT_FADE_MID:  cfg_q.beat_fade_mid  <= cfg_data;
				CFG_BEAT_FADE_HIGH: cfg_q.beat_fade_high <= cfg_data;
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	// Stage handshake: frame starts drain at once, pixels need a free output
	assign adv_out  = !valid_s2 || !out_stall;
	assign take_s1  = valid_s1 && (cmd_s1 == CMD_FRAME || adv_out);
	assign in_stall = valid_s1 && !take_s1;

	// Capture the request in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1    <= cmd_t'(cmd);
			pixel_s1  <= pixel_in;
			beat_s1   <= beat;
			skip_s1   <= skip_frame;
			draw_a_s1 <= draw_a;
			draw_b_s1 <= draw_b;
			draw_c_s1 <= draw_c;
		end
	end

	// Frame-start request to the fader unit
	always_comb begin
		freq.upd    = take_s1 && cmd_s1 == CMD_FRAME;
		freq.beat   = beat_s1;
		freq.skip   = skip_s1;
		freq.draw_a = draw_a_s1;
		freq.draw_b = draw_b_s1;
		freq.draw_c = draw_c_s1;
	end

	dcf_fader u_fader (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (freq),
		.state  (fstate)
	);

	dcf_pixel u_pixel (
		.enabled   (cfg_q.enabled),
		.state     (fstate),
		.pixel_in  (pixel_s1),
		.pixel_out (faded)
	);

	// Advance the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_out) begin
			valid_s2 <= take_s1 && cmd_s1 == CMD_PIXEL;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && take_s1 && cmd_s1 == CMD_PIXEL) begin
			pixel_s2 <= faded;
		end
	end

	assign out_valid = valid_s2;
	assign pixel_out = pixel_s2;

	// Input stalls only behind a pixel blocked by a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && cmd_s1 == CMD_PIXEL && valid_s2 && out_stall)
		else $error("input stalled without a blocked pixel");

	// A pixel leaving the input register shows up on the output
	a_pixel_out: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && cmd_s1 == CMD_PIXEL |=> out_valid)
		else $error("pixel request lost");

	// A frame start never produces a result
	a_frame_silent: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && cmd_s1 == CMD_FRAME && !(valid_s2 && out_stall) |=> !out_valid)
		else $error("frame start produced a result");

endmodule
